[hdl/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define GAODO_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks that a condition never holds while reset is released.
`define GAODO_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[hdl/gaodo_pkg.sv]
package gaodo_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int HEAD_W = 13;
  localparam int POS_W = 48;
  localparam int SCALE_W = 24;
  localparam int CFG_W = 48;
  localparam int CFG_ADDR_W = 2;
  localparam int TRIG_W = 17;
  localparam int MUL_B_W = 18;
  localparam int CHUNK_W = 17;
  localparam int CHUNK_SEL_W = 2;
  localparam int CORDIC_XW = 33;
  localparam int CORDIC_ZW = 25;
  localparam int ATAN_W = 22;
  localparam int ROUND_SHIFT = 15;

  // Angles in 1/16 degree.
  localparam logic signed [13:0] FULL_TURN = 14'sd5760;
  localparam logic signed [13:0] HALF_TURN = 14'sd2880;
  localparam logic signed [13:0] QUARTER_TURN = 14'sd1440;
  localparam logic signed [13:0] WHEEL_A_MOUNT = 14'sd720;
  localparam logic signed [13:0] WHEEL_B_MOUNT = 14'sd2160;

  localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W - 1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};

  localparam logic [CFG_ADDR_W-1:0] CFG_HEADING_OFFSET = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COUNT_SCALE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_X_OFFSET = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_Y_OFFSET = 2'd3;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  typedef struct packed {
    logic                   en;
    logic                   clr;
    logic [CHUNK_SEL_W-1:0] chunk;
  } mac_cmd_t;

  // Width of the sum of two count-by-trig products.
  function automatic int sum_w(input int cw);
    return cw + MUL_B_W;
  endfunction

  // Width of the multiplier's wide operand: a count or the scale factor.
  function automatic int mul_a_w(input int cw);
    return (cw > SCALE_W) ? cw : SCALE_W + 1;
  endfunction

  // Accumulator width that holds a product sum times the scale factor.
  function automatic int acc_w(input int cw);
    return sum_w(cw) + SCALE_W + 1;
  endfunction

  // Arctangent of 2^-i in degrees with 16 fraction bits.
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Offset minus heading, wrapped to (-180, 180] degrees.
  function automatic logic signed [HEAD_W-1:0] wrap_diff(input logic [HEAD_W-1:0] off,
                                                         input logic [HEAD_W-1:0] hd);
    logic signed [13:0] m;
    m = $signed({1'b0, off}) - $signed({1'b0, hd});
    if (m < 0) m = m + FULL_TURN;
    if (m < 0) m = m + FULL_TURN;
    if (m >= FULL_TURN) m = m - FULL_TURN;
    if (m > HALF_TURN) m = m - FULL_TURN;
    return m[HEAD_W-1:0];
  endfunction

  // Adds a wheel mounting angle to a wrapped heading and wraps again.
  function automatic logic signed [HEAD_W-1:0] wrap_mount(input logic signed [HEAD_W-1:0] w,
                                                          input logic signed [13:0] mnt);
    logic signed [13:0] m;
    m = 14'(w) + mnt;
    if (m > HALF_TURN) m = m - FULL_TURN;
    return m[HEAD_W-1:0];
  endfunction

  // Saturates a one-bit-grown difference to the position range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    logic signed [POS_W-1:0] r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/gaodo_in_if.sv]
interface gaodo_in_if #(
  parameter int COUNT_WIDTH = gaodo_pkg::COUNT_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [COUNT_WIDTH-1:0]     count_wheel_a;
  logic signed [COUNT_WIDTH-1:0]     count_wheel_b;
  logic [gaodo_pkg::HEAD_W-1:0]      heading;

  modport source (output valid, output count_wheel_a, output count_wheel_b,
                  output heading, input ready);
  modport sink (input valid, input count_wheel_a, input count_wheel_b,
                input heading, output ready);
endinterface

[hdl/gaodo_out_if.sv]
interface gaodo_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gaodo_pkg::POS_W-1:0]  pos_x;
  logic signed [gaodo_pkg::POS_W-1:0]  pos_y;
  logic signed [gaodo_pkg::HEAD_W-1:0] wrapped_heading;

  modport source (output valid, output pos_x, output pos_y,
                  output wrapped_heading, input ready);
  modport sink (input valid, input pos_x, input pos_y,
                input wrapped_heading, output ready);
endinterface

[hdl/gaodo_cordic.sv]
// Iterative rotation-mode CORDIC: one shift-add step per clock.
module gaodo_cordic #(
  parameter int ITERATIONS = gaodo_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [gaodo_pkg::HEAD_W-1:0] angle_i,
  output logic                               done_o,
  output gaodo_pkg::trig_t                   trig_o
);

  localparam int XW = gaodo_pkg::CORDIC_XW;
  localparam int ZW = gaodo_pkg::CORDIC_ZW;
  localparam int CntW = $clog2(ITERATIONS);
  localparam logic [CntW-1:0] CntLast = CntW'(ITERATIONS - 1);
  localparam int ROUND_SHIFT_FIX = gaodo_pkg::ROUND_SHIFT;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 flip_q, flip_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;

  logic signed [13:0]   ang_w, ang_f;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] t_s;
  logic signed [XW:0]   x_rnd, y_rnd;
  logic signed [XW-ROUND_SHIFT_FIX:0] x_r, y_r;
  logic signed [15:0]   c16, s16;

  // Fold the angle into [-90, 90] degrees; a folded angle's result is negated afterwards.
  always_comb begin
    ang_w = 14'(angle_i);
    flip_d = 1'b0;
    ang_f = ang_w;
    if (ang_w > gaodo_pkg::QUARTER_TURN) begin
      ang_f = ang_w - gaodo_pkg::HALF_TURN;
      flip_d = 1'b1;
    end else if (ang_w < -gaodo_pkg::QUARTER_TURN) begin
      ang_f = ang_w + gaodo_pkg::HALF_TURN;
      flip_d = 1'b1;
    end
  end

  always_comb begin
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    t_s = ZW'(gaodo_pkg::atan_deg(5'(cnt_q)));
    busy_d = busy_q;
    cnt_d = cnt_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = '0;
      x_d = gaodo_pkg::CORDIC_GAIN;
      y_d = '0;
      z_d = ZW'(ang_f) <<< 12;
    end else if (busy_q) begin
      if (!z_q[ZW-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - t_s;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + t_s;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    if (start_i) begin
      flip_q <= flip_d;
    end
  end

  // Round half up to Q1.15 and saturate to the 16-bit range.
  always_comb begin
    x_rnd = (XW + 1)'(x_q) + (XW + 1)'(1 << (ROUND_SHIFT_FIX - 1));
    y_rnd = (XW + 1)'(y_q) + (XW + 1)'(1 << (ROUND_SHIFT_FIX - 1));
    x_r = (XW - ROUND_SHIFT_FIX + 1)'(x_rnd >>> ROUND_SHIFT_FIX);
    y_r = (XW - ROUND_SHIFT_FIX + 1)'(y_rnd >>> ROUND_SHIFT_FIX);
    if (x_r > 32767) c16 = 16'sh7fff;
    else if (x_r < -32768) c16 = 16'sh8000;
    else c16 = x_r[15:0];
    if (y_r > 32767) s16 = 16'sh7fff;
    else if (y_r < -32768) s16 = 16'sh8000;
    else s16 = y_r[15:0];
    if (flip_q) begin
      trig_o.cos_v = -gaodo_pkg::TRIG_W'(c16);
      trig_o.sin_v = -gaodo_pkg::TRIG_W'(s16);
    end else begin
      trig_o.cos_v = gaodo_pkg::TRIG_W'(c16);
      trig_o.sin_v = gaodo_pkg::TRIG_W'(s16);
    end
  end

  assign done_o = done_q;

endmodule

[hdl/gaodo_mac.sv]
// Shared multiply-accumulate unit: a registered product, then a shifted add.
module gaodo_mac #(
  parameter int COUNT_WIDTH = gaodo_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  gaodo_pkg::mac_cmd_t                   cmd_i,
  input  logic signed [gaodo_pkg::mul_a_w(COUNT_WIDTH)-1:0] a_i,
  input  logic signed [gaodo_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [gaodo_pkg::acc_w(COUNT_WIDTH)-1:0]   acc_o
);

  localparam int AW = gaodo_pkg::mul_a_w(COUNT_WIDTH);
  localparam int PW = AW + gaodo_pkg::MUL_B_W;
  localparam int ACCW = gaodo_pkg::acc_w(COUNT_WIDTH);

  gaodo_pkg::mac_cmd_t    cmd1_q;
  logic signed [PW-1:0]   prod_q, prod_d;
  logic signed [ACCW-1:0] acc_q, acc_d;
  logic signed [ACCW-1:0] addend;
  logic [5:0]             sh;

  assign prod_d = a_i * b_i;

  // Each chunk of a wide operand lands CHUNK_W bits further up.
  always_comb begin
    sh = 6'(cmd1_q.chunk) * 6'(gaodo_pkg::CHUNK_W);
    addend = ACCW'(prod_q) <<< sh;
    acc_d = acc_q;
    if (cmd1_q.en) begin
      acc_d = (cmd1_q.clr ? ACCW'(0) : acc_q) + addend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd1_q <= '0;
    end else begin
      cmd1_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

[hdl/gyro_aided_two_wheel_odometry.sv]
// Dead-reckoning odometry for two tracking wheels mounted at 45 and 135 degrees,
// aided by a gyro heading. Each input word carries two signed encoder deltas and
// a heading in 1/16 degree; each one produces exactly one output word with the X
// and Y positions (signed Q32.16 cm, accumulator minus origin offset, saturated)
// and the heading difference (offset minus heading) wrapped to (-180, 180] degrees.
// The work is done one word at a time: the input is not ready while a word is in
// flight, but a finished result waits in its own output register, so the next
// word may be taken while the previous result is still unclaimed. A result that finds
// the output register still occupied holds the sequencer until that register is
// claimed. The work is carried by the single shift-add CORDIC unit, run once per
// wheel angle at one iteration per clock, and by the single multiplier, which forms
// the four count-by-trig products and then multiplies each axis sum by the scale
// factor in 17-bit chunks. Configuration registers are written through the plain
// write port and should only change while no word is in flight. There is no
// clearing pass after reset; both accumulators start at zero.
`include "assert_macros.svh"

module gyro_aided_two_wheel_odometry #(
  parameter int CORDIC_ITERATIONS = gaodo_pkg::CORDIC_ITERATIONS_DEF,
  parameter int COUNT_WIDTH = gaodo_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  gaodo_in_if.sink                             in_i,
  gaodo_out_if.source                          out_o,
  input  logic                                 cfg_we_i,
  input  logic [gaodo_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [gaodo_pkg::CFG_W-1:0]          cfg_wdata_i
);

  localparam int HW = gaodo_pkg::HEAD_W;
  localparam int PSW = gaodo_pkg::POS_W;
  localparam int CHW = gaodo_pkg::CHUNK_W;
  localparam int BW = gaodo_pkg::MUL_B_W;
  localparam int SW = gaodo_pkg::sum_w(COUNT_WIDTH);
  localparam int AW = gaodo_pkg::mul_a_w(COUNT_WIDTH);
  localparam int ACCW = gaodo_pkg::acc_w(COUNT_WIDTH);
  localparam int NCH = (SW + CHW - 1) / CHW;
  localparam int SEW = NCH * CHW;
  localparam int SCW = ACCW - gaodo_pkg::ROUND_SHIFT;
  localparam int NW = ((SCW > PSW) ? SCW : PSW) + 1;

  // Multiply schedule for one axis, in steps of the step counter.
  localparam int ST_LAST = 5 + NCH;
  localparam int StW = $clog2(ST_LAST + 1);
  localparam logic [StW-1:0] ST_PROD_A = StW'(0);
  localparam logic [StW-1:0] ST_PROD_B = StW'(1);
  localparam logic [StW-1:0] ST_SUM = StW'(3);
  localparam logic [StW-1:0] ST_CHUNK0 = StW'(4);
  localparam logic [StW-1:0] ST_CHUNKN = StW'(3 + NCH);
  localparam logic [StW-1:0] ST_APPLY = StW'(ST_LAST);
  localparam logic [gaodo_pkg::CHUNK_SEL_W-1:0] TOP_CHUNK =
    gaodo_pkg::CHUNK_SEL_W'(NCH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CORD_A = 3'd1;
  localparam logic [2:0] S_CORD_B = 3'd2;
  localparam logic [2:0] S_MUL = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  // Configuration registers.
  logic [HW-1:0]                      head_off_q;
  logic [gaodo_pkg::SCALE_W-1:0]      scale_q;
  logic signed [PSW-1:0]              x_off_q, y_off_q;

  // Sequencer and accumulator state.
  logic [2:0]                         state_q, state_d;
  logic [StW-1:0]                     st_q, st_d;
  logic                               ax_q, ax_d;
  logic                               out_valid_q, out_valid_d;
  logic signed [PSW-1:0]              x_acc_q, x_acc_d, y_acc_q, y_acc_d;

  // Per-word working registers.
  logic signed [COUNT_WIDTH-1:0]      cnt_a_q, cnt_b_q;
  logic signed [HW-1:0]               w_q;
  gaodo_pkg::trig_t                   trig_a_q, trig_b_q;
  logic signed [SW-1:0]               sum_q;
  logic signed [PSW-1:0]              x_pos_q, y_pos_q;
  logic signed [HW-1:0]               head_q;

  logic                               accept;
  logic                               load_out;
  logic signed [HW-1:0]               w_new;
  logic                               cor_start;
  logic signed [HW-1:0]               cor_angle;
  logic                               cor_done;
  gaodo_pkg::trig_t                   cor_trig;

  gaodo_pkg::mac_cmd_t                mac_cmd;
  logic signed [AW-1:0]               mac_a;
  logic signed [BW-1:0]               mac_b;
  logic signed [ACCW-1:0]             mac_acc;

  logic [SEW-1:0]                     sum_u;
  logic [gaodo_pkg::CHUNK_SEL_W-1:0]  k;
  logic [5:0]                         k_sh;
  logic [CHW-1:0]                     chunk_raw;
  logic signed [ACCW-1:0]             acc_rnd;
  logic signed [SCW-1:0]              scaled;
  logic signed [NW-1:0]               acc_base, acc_new;
  logic [NW-PSW:0]                    acc_top;
  logic signed [PSW-1:0]              acc_sat;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign w_new = gaodo_pkg::wrap_diff(head_off_q, in_i.heading);

  // The first rotation starts with the accepted word; the second starts as soon
  // as the first one finishes.
  assign cor_start = accept || (state_q == S_CORD_A && cor_done);
  assign cor_angle = (state_q == S_IDLE) ?
                     gaodo_pkg::wrap_mount(w_new, gaodo_pkg::WHEEL_A_MOUNT) :
                     gaodo_pkg::wrap_mount(w_q, gaodo_pkg::WHEEL_B_MOUNT);

  gaodo_cordic #(
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .trig_o  (cor_trig)
  );

  gaodo_mac #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc)
  );

  // The axis sum is fed to the multiplier in 17-bit chunks; only the top chunk
  // carries the sign.
  always_comb begin
    sum_u = SEW'(sum_q);
    k = gaodo_pkg::CHUNK_SEL_W'(st_q - ST_CHUNK0);
    k_sh = 6'(k) * 6'(CHW);
    chunk_raw = CHW'(sum_u >> k_sh);
  end

  // Multiplier command for the current step. X takes cosines, Y takes sines.
  always_comb begin
    mac_cmd = '0;
    mac_a = '0;
    mac_b = '0;
    if (state_q == S_MUL) begin
      if (st_q == ST_PROD_A) begin
        mac_cmd.en = 1'b1;
        mac_cmd.clr = 1'b1;
        mac_a = AW'(cnt_a_q);
        mac_b = ax_q ? BW'(trig_a_q.sin_v) : BW'(trig_a_q.cos_v);
      end else if (st_q == ST_PROD_B) begin
        mac_cmd.en = 1'b1;
        mac_a = AW'(cnt_b_q);
        mac_b = ax_q ? BW'(trig_b_q.sin_v) : BW'(trig_b_q.cos_v);
      end else if (st_q >= ST_CHUNK0 && st_q <= ST_CHUNKN) begin
        mac_cmd.en = 1'b1;
        mac_cmd.clr = (st_q == ST_CHUNK0);
        mac_cmd.chunk = k;
        mac_a = AW'($signed({1'b0, scale_q}));
        mac_b = (k == TOP_CHUNK) ? BW'($signed(chunk_raw)) : $signed({1'b0, chunk_raw});
      end
    end
  end

  // Round the scaled sum half up to Q.16 and fold it into the accumulator of the
  // current axis with saturation; Y is subtracted.
  always_comb begin
    acc_rnd = mac_acc + ACCW'(1 << (gaodo_pkg::ROUND_SHIFT - 1));
    scaled = SCW'(acc_rnd >>> gaodo_pkg::ROUND_SHIFT);
    acc_base = ax_q ? NW'(y_acc_q) : NW'(x_acc_q);
    acc_new = acc_base + (ax_q ? -NW'(scaled) : NW'(scaled));
    acc_top = acc_new[NW-1:PSW-1];
    if (!(&acc_top) && (|acc_top)) begin
      acc_sat = acc_new[NW-1] ? gaodo_pkg::POS_MIN : gaodo_pkg::POS_MAX;
    end else begin
      acc_sat = acc_new[PSW-1:0];
    end
  end

  assign load_out = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    st_d = st_q;
    ax_d = ax_q;
    x_acc_d = x_acc_q;
    y_acc_d = y_acc_q;
    out_valid_d = out_valid_q;
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CORD_A;
        end
      end
      S_CORD_A: begin
        if (cor_done) begin
          state_d = S_CORD_B;
        end
      end
      S_CORD_B: begin
        if (cor_done) begin
          state_d = S_MUL;
          st_d = '0;
          ax_d = 1'b0;
        end
      end
      S_MUL: begin
        if (st_q == ST_APPLY) begin
          if (ax_q) begin
            y_acc_d = acc_sat;
            state_d = S_OUT;
          end else begin
            x_acc_d = acc_sat;
            ax_d = 1'b1;
            st_d = '0;
          end
        end else begin
          st_d = st_q + 1'b1;
        end
      end
      S_OUT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q <= '0;
      ax_q <= 1'b0;
      out_valid_q <= 1'b0;
      x_acc_q <= '0;
      y_acc_q <= '0;
    end else begin
      state_q <= state_d;
      st_q <= st_d;
      ax_q <= ax_d;
      out_valid_q <= out_valid_d;
      x_acc_q <= x_acc_d;
      y_acc_q <= y_acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_off_q <= '0;
      scale_q <= gaodo_pkg::SCALE_RESET;
      x_off_q <= '0;
      y_off_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        gaodo_pkg::CFG_HEADING_OFFSET: head_off_q <= cfg_wdata_i[HW-1:0];
        gaodo_pkg::CFG_COUNT_SCALE:    scale_q <= cfg_wdata_i[gaodo_pkg::SCALE_W-1:0];
        gaodo_pkg::CFG_X_OFFSET:       x_off_q <= cfg_wdata_i[PSW-1:0];
        gaodo_pkg::CFG_Y_OFFSET:       y_off_q <= cfg_wdata_i[PSW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cnt_a_q <= in_i.count_wheel_a;
      cnt_b_q <= in_i.count_wheel_b;
      w_q <= w_new;
    end
    if (state_q == S_CORD_A && cor_done) begin
      trig_a_q <= cor_trig;
    end
    if (state_q == S_CORD_B && cor_done) begin
      trig_b_q <= cor_trig;
    end
    if (state_q == S_MUL && st_q == ST_SUM) begin
      sum_q <= mac_acc[SW-1:0];
    end
    if (load_out) begin
      x_pos_q <= gaodo_pkg::sat_pos((PSW + 1)'(x_acc_q) - (PSW + 1)'(x_off_q));
      y_pos_q <= gaodo_pkg::sat_pos((PSW + 1)'(y_acc_q) - (PSW + 1)'(y_off_q));
      head_q <= w_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.pos_x = x_pos_q;
  assign out_o.pos_y = y_pos_q;
  assign out_o.wrapped_heading = head_q;

  `GAODO_NEVER(a_cordic_done_in_phase, clk_i, rst_ni, cor_done && state_q != S_CORD_A && state_q != S_CORD_B, "CORDIC finished outside a rotation phase")
  `GAODO_ASSERT(a_accept_starts_rotation, clk_i, rst_ni, accept |=> (state_q == S_CORD_A && !in_i.ready), "accepted word did not start the first rotation")
  `GAODO_NEVER(a_step_in_range, clk_i, rst_ni, st_q > ST_APPLY, "multiply step counter ran past its schedule")

endmodule
